>>> rtl/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg - shared types and constants of the line substring filter
// Payload structs of both channels, register map codes and sizing defaults.
// ----------------------------------------------------------------------------
package lsf_pkg;

	// default sizing
	localparam int MAX_PATTERN_DEF = 16;
	localparam int MAX_LINE_DEF    = 1023;

	// pattern storage is fixed by the register map: two 64-bit words
	localparam int PAT_BYTES = 16;
	localparam int PIDX_W    = 4;

	// configuration port
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 64;
	localparam int PLEN_W     = 5;

	// register indexes, taken from paddr[4:3]
	localparam logic [1:0] REG_PAT_LO = 2'd0;
	localparam logic [1:0] REG_PAT_HI = 2'd1;
	localparam logic [1:0] REG_PAT_LEN = 2'd2;
	localparam logic [1:0] REG_INVERT = 2'd3;

	// field widths and special bytes
	localparam int LINE_NUM_W = 32;
	localparam int LINE_LEN_W = 10;
	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam logic [7:0] NUL_BYTE     = 8'd0;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       stream_end;
	} lsf_in_t;

	typedef struct packed {
		logic [LINE_NUM_W-1:0] line_number;
		logic [LINE_LEN_W-1:0] line_length;
		logic                  selected;
	} lsf_out_t;

endpackage

>>> rtl/lsf_match.sv
// ----------------------------------------------------------------------------
// lsf_match - parallel window compare
// Compares the newest searchable bytes against the tail-aligned pattern.
// ----------------------------------------------------------------------------
module lsf_match #(
	parameter int MAX_PATTERN = lsf_pkg::MAX_PATTERN_DEF,
	localparam int SC_W = $clog2(MAX_PATTERN + 1)
) (
	input  logic [MAX_PATTERN-1:0][7:0]        window,
	input  logic [lsf_pkg::PAT_BYTES-1:0][7:0] pattern,
	input  logic [SC_W-1:0]                    pat_len,
	input  logic [SC_W-1:0]                    avail,
	output logic                               hit
);

	logic [lsf_pkg::PIDX_W-1:0] idx;

	// window byte k (k = 0 newest) must equal pattern byte len-1-k
	always_comb begin
		hit = (pat_len != '0) && (avail >= pat_len);
		idx = '0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (SC_W'(k) < pat_len) begin
				idx = lsf_pkg::PIDX_W'(pat_len - SC_W'(1) - SC_W'(k));
				if (pattern[idx] != window[k]) begin
					hit = 1'b0;
				end
			end
		end
	end

endmodule

>>> rtl/line_substring_filter_top.sv
// ----------------------------------------------------------------------------
// line_substring_filter_top - fixed-string line filter over a byte stream
// Splits text into lines at newline and reports, per line, its number,
// kept length and whether it contains the configured pattern, optionally inverted.
// ----------------------------------------------------------------------------
// Usage:
//   text channel: one byte per transaction (text_valid / text_stall). With
//   stream_end set the byte is ignored and a non-empty partial line is
//   flushed as if a newline had arrived.
//   result channel: one transaction per line end (result_valid /
//   result_stall) carrying line_number, line_length and selected.
//   Configuration: APB-style writes, 64-bit registers at 8*index; write only
//   while the block is idle.
// Throughput: one byte per cycle while the receiver does not stall a waiting
//   result. The byte is registered, then the whole window compare and line
//   bookkeeping happen combinationally into the result register, so a result is
//   valid once the byte that ends its line has passed both registers.
// Stall: the input register holds one more byte while a result is waiting;
//   text_stall rises only when both that byte and the result register are
//   occupied and the receiver stalls.
// Reset: line counter returns to one, line state clears, configuration registers clear.
// ----------------------------------------------------------------------------
module line_substring_filter_top #(
	parameter int MAX_PATTERN = lsf_pkg::MAX_PATTERN_DEF,
	parameter int MAX_LINE    = lsf_pkg::MAX_LINE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// text channel
	input  logic                            text_valid,
	output logic                            text_stall,
	input  lsf_pkg::lsf_in_t                text,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output lsf_pkg::lsf_out_t               result,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lsf_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [lsf_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [lsf_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int SC_W   = $clog2(MAX_PATTERN + 1);
	localparam int LINE_W = $clog2(MAX_LINE + 1);
	localparam int EXT_W  = (LINE_W > lsf_pkg::LINE_LEN_W) ? LINE_W : lsf_pkg::LINE_LEN_W;
	localparam int RD     = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

	// configuration registers
	logic [63:0]                 pat_lo_q;
	logic [63:0]                 pat_hi_q;
	logic [lsf_pkg::PLEN_W-1:0]  pat_len_q;
	logic                        invert_q;

	// input stage
	logic                        s1_valid;
	lsf_pkg::lsf_in_t            s1_item;

	// line state
	logic [RD-1:0][7:0]          recent_q;
	logic [LINE_W-1:0]           line_cnt_q;
	logic [SC_W-1:0]             search_cnt_q;
	logic                        nul_q;
	logic                        found_q;
	logic [lsf_pkg::LINE_NUM_W-1:0] line_num_q;

	// result register
	logic                        out_valid_q;
	lsf_pkg::lsf_out_t           out_q;

	logic                        wr_en;
	logic                        advance;
	logic                        accept;
	logic [SC_W-1:0]             eff_len;
	logic [SC_W-1:0]             search_cnt_nxt;
	logic [MAX_PATTERN-1:0][7:0] window;
	logic                        hit;
	logic                        is_newline;
	logic                        line_end;
	logic                        found_end;
	logic [EXT_W-1:0]            len_ext;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= '0;
			invert_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[4:3])
				lsf_pkg::REG_PAT_LO:  pat_lo_q  <= pwdata;
				lsf_pkg::REG_PAT_HI:  pat_hi_q  <= pwdata;
				lsf_pkg::REG_PAT_LEN: pat_len_q <= pwdata[lsf_pkg::PLEN_W-1:0];
				lsf_pkg::REG_INVERT:  invert_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (paddr[4:3])
			lsf_pkg::REG_PAT_LO:  prdata = pat_lo_q;
			lsf_pkg::REG_PAT_HI:  prdata = pat_hi_q;
			lsf_pkg::REG_PAT_LEN: prdata = 64'(pat_len_q);
			lsf_pkg::REG_INVERT:  prdata = 64'(invert_q);
			default:              prdata = '0;
		endcase
	end

	// handshake: process the held byte whenever the result register can take a result
	assign advance      = s1_valid && (!out_valid_q || !result_stall);
	assign text_stall   = s1_valid && !advance;
	assign accept       = text_valid && !text_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// clamp pattern length
	assign eff_len = (pat_len_q > lsf_pkg::PLEN_W'(MAX_PATTERN)) ?
		SC_W'(MAX_PATTERN) : SC_W'(pat_len_q);

	// searchable count after this byte, saturated at the pattern size
	assign search_cnt_nxt = (search_cnt_q == SC_W'(MAX_PATTERN)) ?
		search_cnt_q : search_cnt_q + SC_W'(1);

	// newest byte first, then the stored history
	always_comb begin
		window[0] = s1_item.text_byte;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			window[k] = recent_q[k-1];
		end
	end

	lsf_match #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_match (
		.window (window),
		.pattern({pat_hi_q, pat_lo_q}),
		.pat_len(eff_len),
		.avail  (search_cnt_nxt),
		.hit    (hit)
	);

	assign is_newline = (s1_item.text_byte == lsf_pkg::NEWLINE_BYTE);
	assign line_end   = s1_item.stream_end ? (line_cnt_q != '0) : is_newline;
	assign found_end  = (eff_len == '0) ? (search_cnt_q != '0) : found_q;
	assign len_ext    = EXT_W'(line_cnt_q);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_item <= text;
		end
	end

	// line bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q     <= '0;
			line_cnt_q   <= '0;
			search_cnt_q <= '0;
			nul_q        <= 1'b0;
			found_q      <= 1'b0;
			line_num_q   <= lsf_pkg::LINE_NUM_W'(1);
		end else if (advance) begin
			if (line_end) begin
				recent_q     <= '0;
				line_cnt_q   <= '0;
				search_cnt_q <= '0;
				nul_q        <= 1'b0;
				found_q      <= 1'b0;
				if (line_num_q != '1) begin
					line_num_q <= line_num_q + lsf_pkg::LINE_NUM_W'(1);
				end
			end else if (!s1_item.stream_end && (line_cnt_q < LINE_W'(MAX_LINE))) begin
				line_cnt_q <= line_cnt_q + LINE_W'(1);
				if (!nul_q) begin
					if (s1_item.text_byte == lsf_pkg::NUL_BYTE) begin
						nul_q <= 1'b1;
					end else begin
						search_cnt_q <= search_cnt_nxt;
						found_q      <= found_q || hit;
						recent_q[0]  <= s1_item.text_byte;
						for (int k = 1; k < RD; k++) begin
							recent_q[k] <= recent_q[k-1];
						end
					end
				end
			end
		end
	end

	// result register: load on line end, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && line_end) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && line_end) begin
			out_q.line_number <= line_num_q;
			out_q.line_length <= len_ext[lsf_pkg::LINE_LEN_W-1:0];
			out_q.selected    <= found_end ^ invert_q;
		end
	end

endmodule

>>> rtl/lsf_checker.sv
// ----------------------------------------------------------------------------
// lsf_checker - port-level checks for the line substring filter
// Watches the result channel and input backpressure over time.
// ----------------------------------------------------------------------------
module lsf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              text_stall,
	input logic              result_valid,
	input logic              result_stall,
	input lsf_pkg::lsf_out_t result
);

	logic        seen_q;
	logic [31:0] last_num_q;

	// track the line number of the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_num_q <= '0;
		end else if (result_valid && !result_stall) begin
			seen_q     <= 1'b1;
			last_num_q <= result.line_number;
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// input backpressure only when a result waits on a stalled receiver
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> result_valid && result_stall)
		else $error("text stalled without a blocked result");

	// line numbers start at one
	a_num_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.line_number != 32'd0)
		else $error("line number zero");

	// successive results count up by one until saturation
	a_num_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && seen_q |->
		(result.line_number == last_num_q + 32'd1) ||
		((last_num_q == 32'hFFFF_FFFF) && (result.line_number == 32'hFFFF_FFFF)))
		else $error("line number skipped or repeated");

endmodule

bind line_substring_filter_top lsf_checker u_lsf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.text_stall  (text_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);

>>> sim/tb_line_substring_filter_top.sv
// ----------------------------------------------------------------------------
// tb_line_substring_filter_top - self-checking bench for the line filter
// Feeds byte streams split into lines, planted patterns, NULs, end markers,
// over-long lines and noise under a series of filter settings. A local line
// tracker predicts every line result, and the monitor compares each
// transaction on the result channel field by field, in order.
// ----------------------------------------------------------------------------
module tb_line_substring_filter_top;

	localparam int PHASE_ITEMS   = 80;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 6;
	localparam int LONG_LINE     = 1040;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic              text_valid   = 1'b0;
	logic              text_stall;
	lsf_pkg::lsf_in_t  text         = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	lsf_pkg::lsf_out_t result;

	logic                           psel    = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite  = 1'b0;
	logic [lsf_pkg::APB_ADDR_W-1:0] paddr   = '0;
	logic [lsf_pkg::APB_DATA_W-1:0] pwdata  = '0;
	logic [lsf_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;

	// filter settings as last written
	logic [63:0]                cfg_pat_lo  = '0;
	logic [63:0]                cfg_pat_hi  = '0;
	logic [lsf_pkg::PLEN_W-1:0] cfg_pat_len = '0;
	logic                       cfg_invert  = 1'b0;

	// line tracker state
	logic [7:0]  recent_text [0:lsf_pkg::MAX_PATTERN_DEF-2];
	int          kept_count       = 0;
	int          searchable_count = 0;
	logic        nul_in_line      = 1'b0;
	logic        found_in_line    = 1'b0;
	logic [31:0] line_number_now  = 32'd1;

	lsf_pkg::lsf_in_t  text_queue [$];
	lsf_pkg::lsf_out_t expected_lines [$];

	int items_queued   = 0;
	int items_accepted = 0;
	int lines_checked  = 0;
	int selected_seen  = 0;
	int settings_used  = 0;
	int error_count    = 0;
	int hold_requests  = 0;
	int holds_served   = 0;

	// driver and receiver pacing
	int                burst_left = 1;
	int                gap_left   = 0;
	int                hold_left  = 0;
	int                stall_run  = 0;
	int                stall_mode = 0;
	int                stall_tick = 0;
	lsf_pkg::lsf_out_t want;

	initial begin
		for (int k = 0; k < lsf_pkg::MAX_PATTERN_DEF - 1; k++) recent_text[k] = 8'h00;
	end

	initial forever #5 clk = ~clk;

	line_substring_filter_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text         (text),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	function automatic int active_len();
		return (cfg_pat_len > lsf_pkg::MAX_PATTERN_DEF) ?
			lsf_pkg::MAX_PATTERN_DEF : int'(cfg_pat_len);
	endfunction

	function automatic logic [7:0] pattern_byte(input int i);
		return (i < 8) ? cfg_pat_lo[8*i +: 8] : cfg_pat_hi[8*(i-8) +: 8];
	endfunction

	// report the finished line and start a fresh one
	function automatic void close_line();
		lsf_pkg::lsf_out_t r;
		logic              found;
		found = found_in_line;
		if (active_len() == 0) found = (searchable_count != 0);
		r.line_number = line_number_now;
		r.line_length = kept_count[lsf_pkg::LINE_LEN_W-1:0];
		r.selected    = found ^ cfg_invert;
		expected_lines.push_back(r);
		if (line_number_now != 32'hFFFF_FFFF) line_number_now++;
		for (int k = 0; k < lsf_pkg::MAX_PATTERN_DEF - 1; k++) recent_text[k] = 8'h00;
		kept_count       = 0;
		searchable_count = 0;
		nul_in_line      = 1'b0;
		found_in_line    = 1'b0;
	endfunction

	// compare the window ending in this byte against the pattern, then shift
	function automatic void search_text(input logic [7:0] b);
		int   plen;
		logic hit;
		plen = active_len();
		searchable_count++;
		if (plen > 0 && searchable_count >= plen) begin
			hit = (pattern_byte(plen - 1) == b);
			for (int k = 1; k < plen; k++) begin
				if (pattern_byte(plen - 1 - k) != recent_text[k-1]) hit = 1'b0;
			end
			if (hit) found_in_line = 1'b1;
		end
		for (int k = lsf_pkg::MAX_PATTERN_DEF - 2; k > 0; k--) recent_text[k] = recent_text[k-1];
		recent_text[0] = b;
	endfunction

	function automatic void absorb_text(input lsf_pkg::lsf_in_t t);
		if (t.stream_end) begin
			if (kept_count > 0) close_line();
		end else if (t.text_byte == lsf_pkg::NEWLINE_BYTE) begin
			close_line();
		end else if (kept_count < lsf_pkg::MAX_LINE_DEF) begin
			kept_count++;
			if (!nul_in_line) begin
				if (t.text_byte == lsf_pkg::NUL_BYTE) nul_in_line = 1'b1;
				else search_text(t.text_byte);
			end
		end
	endfunction

	function automatic logic [63:0] random_pattern_word();
		logic [63:0] w;
		for (int i = 0; i < 8; i++) begin
			if ($urandom_range(0, 3) != 0) w[8*i +: 8] = 8'(8'h61 + $urandom_range(0, 3));
			else w[8*i +: 8] = 8'($urandom);
		end
		return w;
	endfunction

	// text driver: bursts with random gaps, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
		end else begin
			if (text_valid && !text_stall) begin
				absorb_text(text);
				items_accepted++;
			end
			if (!(text_valid && text_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					text_valid <= 1'b0;
				end else if (text_queue.size() != 0) begin
					text       <= text_queue.pop_front();
					text_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_lines.size() == 0) begin
					$error("result transaction with no line pending: line_number %0d",
						result.line_number);
					error_count++;
				end else begin
					want = expected_lines.pop_front();
					if (result.line_number !== want.line_number) begin
						$error("line_number: expected %0d, got %0d",
							want.line_number, result.line_number);
						error_count++;
					end
					if (result.line_length !== want.line_length) begin
						$error("line_length: expected %0d, got %0d",
							want.line_length, result.line_length);
						error_count++;
					end
					if (result.selected !== want.selected) begin
						$error("selected: expected %0d, got %0d", want.selected, result.selected);
						error_count++;
					end
					lines_checked++;
					if (want.selected) selected_seen++;
				end
			end
			stall_tick++;
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD - 1;
				result_stall <= 1'b1;
			end else begin
				if (stall_run == 0) begin
					stall_mode = $urandom_range(0, 3);
					stall_run  = $urandom_range(4, 60);
				end
				stall_run--;
				case (stall_mode)
					0: result_stall <= 1'b0;
					1: result_stall <= 1'($urandom);
					2: result_stall <= ($urandom_range(0, 3) != 0);
					default: result_stall <= (stall_tick % 5 == 0);
				endcase
			end
		end
	end

	// write one register, then read it back
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		logic [63:0] rd_want;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		rd_want = '0;
		case (idx)
			lsf_pkg::REG_PAT_LO: begin
				cfg_pat_lo = value;
				rd_want    = value;
			end
			lsf_pkg::REG_PAT_HI: begin
				cfg_pat_hi = value;
				rd_want    = value;
			end
			lsf_pkg::REG_PAT_LEN: begin
				cfg_pat_len = value[lsf_pkg::PLEN_W-1:0];
				rd_want     = 64'(value[lsf_pkg::PLEN_W-1:0]);
			end
			lsf_pkg::REG_INVERT: begin
				cfg_invert = value[0];
				rd_want    = 64'(value[0]);
			end
			default: ;
		endcase
		@(negedge clk);
		if (prdata !== rd_want) begin
			$error("prdata: expected %0h, got %0h", rd_want, prdata);
			error_count++;
		end
	endtask

	// write all four registers; upper bits of the narrow ones carry junk
	task automatic set_filter(input logic [63:0] lo, input logic [63:0] hi,
			input logic [lsf_pkg::PLEN_W-1:0] plen, input logic inv);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		write_reg(lsf_pkg::REG_PAT_LO, lo);
		write_reg(lsf_pkg::REG_PAT_HI, hi);
		write_reg(lsf_pkg::REG_PAT_LEN, {junk[63:lsf_pkg::PLEN_W], plen});
		write_reg(lsf_pkg::REG_INVERT, {junk[63:1], inv});
		settings_used++;
	endtask

	task automatic queue_item(input logic [7:0] b, input logic fin);
		lsf_pkg::lsf_in_t t;
		t.text_byte  = b;
		t.stream_end = fin;
		text_queue.push_back(t);
		items_queued++;
	endtask

	task automatic queue_string(input string s);
		for (int i = 0; i < s.len(); i++) queue_item(s[i], 1'b0);
	endtask

	// one line of text biased toward the pattern, then mostly its terminator
	task automatic queue_line(input int body_len);
		logic [7:0] body [$];
		logic [7:0] b;
		int         plen;
		int         at;
		int         pick;
		plen = active_len();
		for (int i = 0; i < body_len; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40 && plen > 0) begin
				b = pattern_byte($urandom_range(0, plen - 1));
			end else if (pick < 75) begin
				b = 8'(8'h61 + $urandom_range(0, 3));
			end else begin
				b = 8'($urandom);
				if (b == lsf_pkg::NEWLINE_BYTE) b = 8'hFF;
			end
			body.push_back(b);
		end
		// plant the whole pattern
		if (plen > 0 && body_len >= plen && $urandom_range(0, 99) < 60) begin
			at = $urandom_range(0, body_len - plen);
			for (int k = 0; k < plen; k++) body[at+k] = pattern_byte(k);
		end
		if (body_len > 0 && $urandom_range(0, 9) == 0)
			body[$urandom_range(0, body_len - 1)] = lsf_pkg::NUL_BYTE;
		foreach (body[i]) queue_item(body[i], 1'b0);
		pick = $urandom_range(0, 99);
		if (pick < 80) queue_item(lsf_pkg::NEWLINE_BYTE, 1'b0);
		else if (pick < 95) queue_item(8'($urandom), 1'b1);
		// otherwise run on into the next line
	endtask

	// wait until every queued transaction is taken and every line reported
	task automatic drain_all();
		@(negedge clk);
		while (items_accepted != items_queued || expected_lines.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [63:0] lo;
		logic [7:0]  b;
		int          phase_start;
		int          pick;
		int          plen;
		int          guard;
		logic        paused;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// pattern "abc": hit, empty line, NUL cutoff, end markers
		set_filter(64'hDEAD_BEEF_0063_6261, '1, 5'd3, 1'b0);
		queue_string("zabc\n");
		queue_string("\n");
		queue_string("a");
		queue_item(lsf_pkg::NUL_BYTE, 1'b0);
		queue_string("abc\n");
		queue_item(8'hFF, 1'b1);
		queue_string("xab");
		queue_item(lsf_pkg::NEWLINE_BYTE, 1'b1);
		queue_item(8'hFF, 1'b0);
		queue_item(lsf_pkg::NEWLINE_BYTE, 1'b0);
		drain_all();

		// empty pattern, inverted: a line of only NUL has nothing searchable
		set_filter('0, '0, 5'd0, 1'b1);
		queue_item(lsf_pkg::NUL_BYTE, 1'b0);
		queue_item(lsf_pkg::NEWLINE_BYTE, 1'b0);
		queue_string("q\n");
		queue_string("\n");
		drain_all();

		paused = 1'b0;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_filter('1, '1, 5'd16, 1'b0);
				1: set_filter(random_pattern_word(), random_pattern_word(), 5'd31, 1'b1);
				2: set_filter(random_pattern_word(), random_pattern_word(), 5'd1, 1'b0);
				3: set_filter('0, '0, 5'd0, 1'b0);
				4: begin
					lo = random_pattern_word();
					lo[23:16] = lsf_pkg::NUL_BYTE;
					set_filter(lo, random_pattern_word(), 5'd5, 1'b1);
				end
				default: set_filter(random_pattern_word(), random_pattern_word(),
					5'($urandom_range(0, 16)), 1'($urandom));
			endcase

			// one over-long line with the pattern past the kept part
			if (p == 5) begin
				plen = active_len();
				for (int i = 0; i < LONG_LINE; i++) begin
					if (i >= 1025 && i - 1025 < plen) b = pattern_byte(i - 1025);
					else b = 8'(8'h61 + $urandom_range(0, 3));
					queue_item(b, 1'b0);
				end
				queue_item(lsf_pkg::NEWLINE_BYTE, 1'b0);
			end

			phase_start = items_queued;
			while (items_queued - phase_start < PHASE_ITEMS) begin
				if (p == 2 && !paused && items_queued - phase_start >= PHASE_ITEMS / 2) begin
					drain_all();
					paused = 1'b1;
				end
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					// noise: any byte, stray end markers
					repeat ($urandom_range(1, 6))
						queue_item(8'($urandom), $urandom_range(0, 3) == 0);
				end else if (pick < 18) begin
					queue_line(0);
				end else if (pick < 85) begin
					queue_line($urandom_range(1, 20));
				end else begin
					queue_line($urandom_range(21, 80));
				end
			end

			// hold the receiver off while the sender keeps offering bytes
			if (p == 3) begin
				repeat (20) @(negedge clk);
				hold_requests++;
			end
			drain_all();
		end

		while (items_accepted != items_queued) @(negedge clk);
		guard = 0;
		while (expected_lines.size() != 0 && guard < 5000) begin
			@(negedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_lines.size() != 0) begin
			$error("%0d line results never arrived", expected_lines.size());
			error_count++;
		end

		$display("run covered %0d text transactions under %0d filter settings",
			items_accepted, settings_used);
		$display("%0d line results checked, %0d of them selected, %0d mismatches",
			lines_checked, selected_seen, error_count);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
